// ----- rtl/spam_pkg.sv -----
// Shared types and constants for the sparse polynomial add/merge block.
// No dependencies; imported by spam_term_ram and sparse_polynomial_add_merge_core.
`timescale 1ns / 1ps
`default_nettype none

package spam_pkg;

  localparam int MAX_TERMS = 32;
  localparam int TERM_AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CMP
  } st_t;

  typedef struct packed {
    logic signed [31:0] coeff;
    logic signed [31:0] exp;
  } term_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] term_coeff;
    logic signed [31:0] term_exp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sum_coeff;
    logic signed [31:0] sum_exp;
    logic               last_term;
    logic               empty_result;
    logic               load_overflow;
  } out_item_t;

  // write side of one term store
  typedef struct packed {
    logic               we;
    logic [TERM_AW-1:0] waddr;
    term_t              wdata;
  } ram_wr_t;

endpackage

`default_nettype wire

// ----- rtl/sparse_polynomial_add_merge_core.sv -----
// Top level of the sparse polynomial adder: load path, merge sequencer, output register.
// Uses spam_pkg and two spam_term_ram instances.
`timescale 1ns / 1ps
`default_nettype none

// Loads (opcode 0/1) append a term to list A or B and can follow each other
// directly; a load into a full list is dropped and sets the sticky
// load_overflow flag. A merge (opcode 2) streams the sum in head-to-head
// order: each result term passes through the registered read of both term
// stores (S_FETCH) and then the shared compare/add (S_CMP), which waits while
// the output is stalled. A merge of two empty lists gives one result flagged
// empty_result. The input is stalled from the merge transfer until its last
// result is taken. Both lists are empty after a merge; the overflow flag
// clears only on reset.
module sparse_polynomial_add_merge_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire spam_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output spam_pkg::out_item_t       out_data
);
  import spam_pkg::*;

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] idx_a_r, idx_a_nxt;
  logic [CNT_W-1:0] idx_b_r, idx_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  ram_wr_t          wr_a, wr_b;
  term_t            rd_a, rd_b;

  logic             accept_in;
  logic             out_free;
  logic             is_merge;
  logic             full_a, full_b;

  // shared compare/add unit
  logic             has_a, has_b;
  logic             exp_eq, a_gt;
  logic             take_a, take_b;
  logic signed [31:0] res_coeff, res_exp;
  logic [CNT_W-1:0] step_a, step_b;
  logic             res_last;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_merge  = accept_in && (in_data.opcode == OP_MERGE);
  assign full_a    = (cnt_a_r >= CNT_W'(MAX_TERMS));
  assign full_b    = (cnt_b_r >= CNT_W'(MAX_TERMS));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    wr_a.we    = accept_in && (in_data.opcode == OP_LOAD_A) && !full_a;
    wr_a.waddr = cnt_a_r[TERM_AW-1:0];
    wr_a.wdata = '{coeff: in_data.term_coeff, exp: in_data.term_exp};
    wr_b.we    = accept_in && (in_data.opcode == OP_LOAD_B) && !full_b;
    wr_b.waddr = cnt_b_r[TERM_AW-1:0];
    wr_b.wdata = '{coeff: in_data.term_coeff, exp: in_data.term_exp};
  end

  spam_term_ram u_ram_a (
    .clk   (clk),
    .wr    (wr_a),
    .raddr (idx_a_r[TERM_AW-1:0]),
    .rdata (rd_a)
  );

  spam_term_ram u_ram_b (
    .clk   (clk),
    .wr    (wr_b),
    .raddr (idx_b_r[TERM_AW-1:0]),
    .rdata (rd_b)
  );

  // pick head(s), add on equal exponents
  always_comb begin
    has_a  = idx_a_r < cnt_a_r;
    has_b  = idx_b_r < cnt_b_r;
    exp_eq = rd_a.exp == rd_b.exp;
    a_gt   = rd_a.exp > rd_b.exp;
    if (has_a && has_b) begin
      take_a = exp_eq || a_gt;
      take_b = exp_eq || !a_gt;
    end else begin
      take_a = has_a;
      take_b = !has_a;
    end
    if (take_a && take_b) begin
      res_coeff = rd_a.coeff + rd_b.coeff;
    end else if (take_a) begin
      res_coeff = rd_a.coeff;
    end else begin
      res_coeff = rd_b.coeff;
    end
    res_exp  = take_a ? rd_a.exp : rd_b.exp;
    step_a   = idx_a_r + CNT_W'(take_a);
    step_b   = idx_b_r + CNT_W'(take_b);
    res_last = (step_a >= cnt_a_r) && (step_b >= cnt_b_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (is_merge && ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          state_nxt = res_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and counters
  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          case (in_data.opcode)
            OP_LOAD_A: begin
              if (full_a) begin
                ovf_nxt = 1'b1;
              end else begin
                cnt_a_nxt = cnt_a_r + CNT_W'(1);
              end
            end
            OP_LOAD_B: begin
              if (full_b) begin
                ovf_nxt = 1'b1;
              end else begin
                cnt_b_nxt = cnt_b_r + CNT_W'(1);
              end
            end
            OP_MERGE: begin
              idx_a_nxt = '0;
              idx_b_nxt = '0;
              if ((cnt_a_r == '0) && (cnt_b_r == '0)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{sum_coeff: '0, sum_exp: '0, last_term: 1'b1,
                                  empty_result: 1'b1, load_overflow: ovf_r};
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sum_coeff: res_coeff, sum_exp: res_exp,
                            last_term: res_last, empty_result: 1'b0,
                            load_overflow: ovf_r};
          idx_a_nxt = step_a;
          idx_b_nxt = step_b;
          if (res_last) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // input transfers only happen while the sequencer is idle
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |-> (state_r == S_IDLE))
    else $error("input transfer while merge in progress");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(MAX_TERMS)) && (cnt_b_r <= CNT_W'(MAX_TERMS)))
    else $error("list count beyond capacity");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((idx_a_r <= cnt_a_r) && (idx_b_r <= cnt_b_r)))
    else $error("merge index past list end");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.empty_result) |-> out_data_r.last_term)
    else $error("empty result not flagged last");

  // a merge that starts on non-empty lists ends with counts cleared
  a_merge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CMP) && (state_nxt == S_IDLE)) |=>
      ((cnt_a_r == '0) && (cnt_b_r == '0)))
    else $error("lists not emptied after merge");

endmodule

`default_nettype wire

// ----- rtl/spam_term_ram.sv -----
// Term store: MAX_TERMS entries of coefficient/exponent, one write port,
// one read port with registered read data. Uses spam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spam_term_ram (
  input  wire logic                     clk,
  input  wire spam_pkg::ram_wr_t        wr,
  input  wire logic [spam_pkg::TERM_AW-1:0] raddr,
  output spam_pkg::term_t               rdata
);
  import spam_pkg::*;

  term_t mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
